/* hw/rtl/ptt_pkg.sv */
// Shared types and constants for the periodic task timer bank.
// No dependencies; used by the core, the port checker and the bench.
package ptt_pkg;

  localparam int LIST_COUNT           = 3;
  localparam int TASKS_PER_LIST_DEF   = 16;
  localparam int PERIOD_BITS_DEF      = 32;
  localparam int RESULT_LIMIT         = 16;
  localparam int FIRE_CNT_W           = $clog2(RESULT_LIMIT + 1);
  localparam int IN_PERIOD_W          = 32;
  localparam int RES_IDX_W            = 4;

  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_SET  = 2'd1,
    REQ_TICK = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_SET  = 2'd1,
    KIND_FIRE = 2'd2,
    KIND_IDLE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

/* hw/rtl/ptt_store.sv */
// Entry store: period and countdown of every entry of every list.
// One write port, one read port with registered read data. No package use.
module ptt_store #(
  parameter int DEPTH = 48,
  parameter int AW    = 6,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/periodic_task_timer_bank_core.sv */
// Periodic task timer bank, top level.
// Depends on ptt_pkg and ptt_store.
//
// Three lists of periodic timers share one entry store (period and countdown
// per entry, registered read data). An add or set request writes the entry
// and puts its reply in the output register as it is accepted.
// A tick on a list first accepts the request and starts the first read,
// then does a read-modify-write of each of its entries, one entry per cycle
// while the output is not stalled, through the store's single read port,
// then emits the closing result. A tick on an empty list, or on list 3,
// skips the scan and emits only the closing result. Fire results are held
// back one deep so the final one can carry last; a tick that fires nothing
// gives one fired-none result. No new request is taken while a tick is in
// progress, or while a result sits in the output register and is stalled.
// Downstream stall pauses the scan. No clearing pass is needed after reset:
// only entries below a list's count are ever read.
module periodic_task_timer_bank_core #(
  parameter int TASKS_PER_LIST = ptt_pkg::TASKS_PER_LIST_DEF,
  parameter int PERIOD_BITS    = ptt_pkg::PERIOD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_req_type,
  input  logic [1:0]                       in_task_list,
  input  logic [3:0]                       in_entry_index,
  input  logic [ptt_pkg::IN_PERIOD_W-1:0]  in_period_value,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_result_kind,
  output logic [ptt_pkg::RES_IDX_W-1:0]    out_result_index,
  output logic                             out_status,
  output logic                             out_last
);

  // index into a list, count per list (holds TASKS_PER_LIST itself)
  localparam int IW    = (TASKS_PER_LIST > 1) ? $clog2(TASKS_PER_LIST) : 1;
  localparam int CW    = $clog2(TASKS_PER_LIST + 1);
  localparam int DEPTH = ptt_pkg::LIST_COUNT * TASKS_PER_LIST;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = 2 * PERIOD_BITS;
  localparam int CMPW  = (CW > 4) ? CW : 4;
  localparam int FW    = ptt_pkg::FIRE_CNT_W;

  // control state
  ptt_pkg::state_t state_r, state_nxt;
  logic [1:0]      list_r, list_nxt;
  logic [CW-1:0]   n_r, n_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [FW-1:0]   fires_r, fires_nxt;
  logic            pend_v_r, pend_v_nxt;
  logic [CW-1:0]   cnt_r   [ptt_pkg::LIST_COUNT];
  logic [CW-1:0]   cnt_nxt [ptt_pkg::LIST_COUNT];
  logic            out_valid_r, out_valid_nxt;

  // payload
  logic [3:0]      pend_idx_r, pend_idx_nxt;
  ptt_pkg::kind_t  kind_r, kind_nxt;
  logic [3:0]      ridx_r, ridx_nxt;
  logic            status_r, status_nxt;
  logic            last_r, last_nxt;

  // store port
  logic            st_we;
  logic [AW-1:0]   st_waddr;
  logic [DW-1:0]   st_wdata;
  logic [AW-1:0]   st_raddr;
  logic [DW-1:0]   st_rdata;

  // datapath
  logic            in_acc;
  logic            can_push;
  logic            list_ok;
  logic [CW-1:0]   cnt_sel;
  logic [1:0]      lst_sel;
  logic [AW-1:0]   base;
  logic [PERIOD_BITS-1:0] per_in;
  logic [PERIOD_BITS-1:0] rd_per;
  logic [PERIOD_BITS-1:0] rd_cnt;
  logic [PERIOD_BITS-1:0] dec;
  logic            fire;
  logic            scan_go;
  logic            scan_last;
  logic            set_ok;

  ptt_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // output register frees up this cycle, or is already free
  assign can_push = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ptt_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  assign per_in   = PERIOD_BITS'(in_period_value);
  assign list_ok  = (in_task_list != 2'd3);
  assign lst_sel  = (state_r == ptt_pkg::ST_IDLE) ? in_task_list : list_r;

  always_comb begin
    case (lst_sel)
      2'd0:    base = '0;
      2'd1:    base = AW'(TASKS_PER_LIST);
      2'd2:    base = AW'(2 * TASKS_PER_LIST);
      default: base = '0;
    endcase
  end

  always_comb begin
    case (in_task_list)
      2'd0:    cnt_sel = cnt_r[0];
      2'd1:    cnt_sel = cnt_r[1];
      2'd2:    cnt_sel = cnt_r[2];
      default: cnt_sel = '0;
    endcase
  end

  assign set_ok = list_ok && (CMPW'(in_entry_index) < CMPW'(cnt_sel));

  // entry under the scan: read data belongs to idx_r
  assign rd_per    = st_rdata[DW-1:PERIOD_BITS];
  assign rd_cnt    = st_rdata[PERIOD_BITS-1:0];
  assign dec       = rd_cnt - PERIOD_BITS'(1);
  assign fire      = (rd_per != '0) && (dec == '0);
  assign scan_go   = (state_r == ptt_pkg::ST_SCAN) && can_push;
  assign scan_last = ((CW'(idx_r) + CW'(1)) == n_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptt_pkg::ST_IDLE: begin
        if (in_acc && (in_req_type == ptt_pkg::REQ_TICK)) begin
          if (list_ok && (cnt_sel != '0)) begin
            state_nxt = ptt_pkg::ST_SCAN;
          end else begin
            state_nxt = ptt_pkg::ST_DONE;
          end
        end
      end
      ptt_pkg::ST_SCAN: begin
        if (scan_go && scan_last) begin
          state_nxt = ptt_pkg::ST_DONE;
        end
      end
      ptt_pkg::ST_DONE: begin
        if (can_push) begin
          state_nxt = ptt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ptt_pkg::ST_IDLE;
    endcase
  end

  // datapath, store access and result register
  always_comb begin
    list_nxt      = list_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    fires_nxt     = fires_r;
    pend_v_nxt    = pend_v_r;
    pend_idx_nxt  = pend_idx_r;
    for (int l = 0; l < ptt_pkg::LIST_COUNT; l++) begin
      cnt_nxt[l] = cnt_r[l];
    end
    // a taken result leaves the register unless replaced below
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    ridx_nxt      = ridx_r;
    status_nxt    = status_r;
    last_nxt      = last_r;
    st_we         = 1'b0;
    st_waddr      = base + AW'(idx_r);
    st_wdata      = {per_in, per_in};
    st_raddr      = base + AW'(idx_r);

    case (state_r)
      ptt_pkg::ST_IDLE: begin
        st_raddr = base;
        if (in_acc) begin
          case (in_req_type)
            ptt_pkg::REQ_ADD: begin
              out_valid_nxt = 1'b1;
              kind_nxt      = ptt_pkg::KIND_ADD;
              last_nxt      = 1'b1;
              if (list_ok && (cnt_sel < CW'(TASKS_PER_LIST))) begin
                st_we    = 1'b1;
                st_waddr = base + AW'(cnt_sel);
                for (int l = 0; l < ptt_pkg::LIST_COUNT; l++) begin
                  if (in_task_list == 2'(l)) begin
                    cnt_nxt[l] = cnt_sel + CW'(1);
                  end
                end
                ridx_nxt   = 4'(cnt_sel);
                status_nxt = 1'b0;
              end else begin
                ridx_nxt   = '0;
                status_nxt = 1'b1;
              end
            end
            ptt_pkg::REQ_SET: begin
              out_valid_nxt = 1'b1;
              kind_nxt      = ptt_pkg::KIND_SET;
              ridx_nxt      = in_entry_index;
              status_nxt    = !set_ok;
              last_nxt      = 1'b1;
              if (set_ok) begin
                st_we    = 1'b1;
                st_waddr = base + AW'(in_entry_index);
              end
            end
            ptt_pkg::REQ_TICK: begin
              list_nxt   = in_task_list;
              n_nxt      = cnt_sel;
              idx_nxt    = '0;
              fires_nxt  = '0;
              pend_v_nxt = 1'b0;
            end
            default: ;  // unused request code: no results
          endcase
        end
      end

      ptt_pkg::ST_SCAN: begin
        if (scan_go) begin
          if (!scan_last) begin
            st_raddr = base + AW'(idx_r) + AW'(1);
          end
          idx_nxt = idx_r + IW'(1);
          if (rd_per != '0) begin
            st_we    = 1'b1;
            st_wdata = {rd_per, (fire ? rd_per : dec)};
          end
          // hold the newest fire back; flush the older one
          if (fire && (fires_r < FW'(ptt_pkg::RESULT_LIMIT))) begin
            fires_nxt    = fires_r + FW'(1);
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = 4'(idx_r);
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              kind_nxt      = ptt_pkg::KIND_FIRE;
              ridx_nxt      = pend_idx_r;
              status_nxt    = 1'b0;
              last_nxt      = 1'b0;
            end
          end
        end
      end

      ptt_pkg::ST_DONE: begin
        if (can_push) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = pend_v_r ? ptt_pkg::KIND_FIRE : ptt_pkg::KIND_IDLE;
          ridx_nxt      = pend_v_r ? pend_idx_r : 4'd0;
          status_nxt    = 1'b0;
          last_nxt      = 1'b1;
          pend_v_nxt    = 1'b0;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptt_pkg::ST_IDLE;
      list_r      <= '0;
      n_r         <= '0;
      idx_r       <= '0;
      fires_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int l = 0; l < ptt_pkg::LIST_COUNT; l++) begin
        cnt_r[l] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      list_r      <= list_nxt;
      n_r         <= n_nxt;
      idx_r       <= idx_nxt;
      fires_r     <= fires_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      for (int l = 0; l < ptt_pkg::LIST_COUNT; l++) begin
        cnt_r[l] <= cnt_nxt[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    kind_r     <= kind_nxt;
    ridx_r     <= ridx_nxt;
    status_r   <= status_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = kind_r;
  assign out_result_index = ridx_r;
  assign out_status       = status_r;
  assign out_last         = last_r;

endmodule

/* hw/rtl/ptt_checker.sv */
// Port-level checker for the periodic task timer bank, bound to the core.
// Depends on ptt_pkg for request and result codes.
module ptt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_req_type,
  input logic [1:0]  in_task_list,
  input logic [3:0]  in_entry_index,
  input logic [31:0] in_period_value,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_result_kind,
  input logic [3:0]  out_result_index,
  input logic        out_status,
  input logic        out_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind) &&
      $stable(out_result_index) && $stable(out_status) && $stable(out_last))
    else $error("stalled result changed");

  // add reply shows up in the next cycle, as a single result
  a_add_reply: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type == ptt_pkg::REQ_ADD) |=>
      out_valid && (out_result_kind == ptt_pkg::KIND_ADD) && out_last)
    else $error("add reply missing");

  // a tick keeps the request side closed the following cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type == ptt_pkg::REQ_TICK) |=> in_stall)
    else $error("request taken during tick");

  // fire and fired-none results never report failure; fired-none is alone
  a_tick_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_result_kind == ptt_pkg::KIND_FIRE) ||
      (out_result_kind == ptt_pkg::KIND_IDLE)) |->
      !out_status && ((out_result_kind == ptt_pkg::KIND_FIRE) ||
        (out_last && (out_result_index == 4'd0))))
    else $error("bad tick result");

endmodule

bind periodic_task_timer_bank_core ptt_checker u_ptt_checker (.*);

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for periodic_task_timer_bank_core: random add, set and tick requests.
// Depends on ptt_pkg and the core RTL; it predicts every result and checks each one in order.
module tb;

  localparam int          TASKS         = ptt_pkg::TASKS_PER_LIST_DEF;
  localparam int          TIMEOUT_LIMIT = 400000;
  localparam int          DRAIN_CYCLES  = 40;
  localparam logic [1:0]  REQ_UNUSED    = 2'd3; // request code the core ignores
  localparam logic [1:0]  NO_LIST       = 2'd3; // list code that is always empty and full

  // idling phases
  localparam int PH_QUIET      = 0;
  localparam int PH_SEND_GAPS  = 1;
  localparam int PH_RECV_STALL = 2;
  localparam int PH_BOTH       = 3;

  typedef struct packed {
    logic [1:0]  req;
    logic [1:0]  list;
    logic [3:0]  index;
    logic [31:0] period;
  } timer_req_t;

  typedef struct packed {
    ptt_pkg::kind_t kind;
    logic [3:0]     index;
    logic           status;
    logic           last;
  } timer_result_t;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type     = '0;
  logic [1:0]  in_task_list    = '0;
  logic [3:0]  in_entry_index  = '0;
  logic [31:0] in_period_value = '0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [1:0]  out_result_kind;
  logic [3:0]  out_result_index;
  logic        out_status;
  logic        out_last;

  timer_req_t    request_q[$];
  timer_req_t    on_bus;
  timer_req_t    next_request;
  timer_result_t expected_results[$];
  timer_result_t oldest_result;

  // mirror of the timer bank
  int          entries_in_list[ptt_pkg::LIST_COUNT];
  logic [31:0] period_mirror   [ptt_pkg::LIST_COUNT][TASKS];
  logic [31:0] countdown_mirror[ptt_pkg::LIST_COUNT][TASKS];

  int request_total  = 0;
  int accepted_count = 0;
  int idle_phase     = PH_QUIET;
  int error_count    = 0;
  int cycle_count    = 0;
  int gen_count[ptt_pkg::LIST_COUNT];
  int gen_useful     = 0;

  periodic_task_timer_bank_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_task_list     (in_task_list),
    .in_entry_index   (in_entry_index),
    .in_period_value  (in_period_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_result_index (out_result_index),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic int send_gap_pct(input int ph);
    case (ph)
      PH_SEND_GAPS: return 54;
      PH_BOTH:      return 9;
      default:      return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(input int ph);
    case (ph)
      PH_RECV_STALL: return 54;
      PH_BOTH:       return 9;
      default:       return 0;
    endcase
  endfunction

  // Works out the results of one accepted request and updates the mirror.
  function automatic void predict_timer_results(input timer_req_t r);
    timer_result_t res;
    timer_result_t held;
    bit            have_held;
    int            fired;
    int            slot;
    logic [31:0]   next_count;
    res       = '0;
    held      = '0;
    have_held = 0;
    fired     = 0;
    res.last  = 1'b1;
    case (r.req)
      ptt_pkg::REQ_ADD: begin
        res.kind = ptt_pkg::KIND_ADD;
        if (r.list == NO_LIST || entries_in_list[r.list] >= TASKS) begin
          // full list or list 3: nothing stored, index reads 0
          res.status = 1'b1;
        end else begin
          slot = entries_in_list[r.list];
          period_mirror[r.list][slot]    = r.period;
          countdown_mirror[r.list][slot] = r.period;
          entries_in_list[r.list]        = slot + 1;
          res.index = slot[3:0];
        end
        expected_results.push_back(res);
      end
      ptt_pkg::REQ_SET: begin
        res.kind  = ptt_pkg::KIND_SET;
        res.index = r.index;
        if (r.list == NO_LIST || r.index >= entries_in_list[r.list]) begin
          res.status = 1'b1;
        end else begin
          period_mirror[r.list][r.index]    = r.period;
          countdown_mirror[r.list][r.index] = r.period;
        end
        expected_results.push_back(res);
      end
      ptt_pkg::REQ_TICK: begin
        if (r.list != NO_LIST) begin
          for (int i = 0; i < entries_in_list[r.list]; i++) begin
            if (period_mirror[r.list][i] != '0) begin
              next_count = countdown_mirror[r.list][i] - 32'd1;
              if (next_count == '0) begin
                next_count = period_mirror[r.list][i];
                if (fired < ptt_pkg::RESULT_LIMIT) begin
                  // hold one back so the final fire can carry last
                  if (have_held) expected_results.push_back(held);
                  held       = '0;
                  held.kind  = ptt_pkg::KIND_FIRE;
                  held.index = i[3:0];
                  have_held  = 1;
                  fired++;
                end
              end
              countdown_mirror[r.list][i] = next_count;
            end
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          expected_results.push_back(held);
        end else begin
          res.kind = ptt_pkg::KIND_IDLE;
          expected_results.push_back(res);
        end
      end
      default: ; // unused request code: no result
    endcase
  endfunction

  function automatic void queue_request(input logic [1:0] req, input logic [1:0] list,
                                        input logic [3:0] index, input logic [31:0] period);
    timer_req_t r;
    r.req    = req;
    r.list   = list;
    r.index  = index;
    r.period = period;
    request_q.push_back(r);
    if (req != REQ_UNUSED) gen_useful++;
    if (req == ptt_pkg::REQ_ADD && list != NO_LIST && gen_count[list] < TASKS)
      gen_count[list]++;
  endfunction

  // mostly short periods so that entries actually fire
  function automatic logic [31:0] pick_period();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 75) return $urandom_range(1, 4);
    if (roll < 85) return $urandom_range(5, 40);
    return $urandom;
  endfunction

  // Driver: presents queued requests, holds each until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_timer_results(on_bus);
        accepted_count++;
        idle_phase <= (accepted_count * 4 >= request_total * 4) ? PH_BOTH :
                      (accepted_count * 4) / request_total;
      end
      if (!in_valid || !in_stall) begin
        if (request_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct(idle_phase)) begin
          next_request     = request_q.pop_front();
          on_bus          <= next_request;
          in_req_type     <= next_request.req;
          in_task_list    <= next_request.list;
          in_entry_index  <= next_request.index;
          in_period_value <= next_request.period;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d index %0d",
                                    out_result_kind, out_result_index));
        end else begin
          oldest_result = expected_results.pop_front();
          if (out_result_kind != oldest_result.kind)
            report_mismatch($sformatf("kind got %0d exp %0d",
                                      out_result_kind, oldest_result.kind));
          if (out_result_index != oldest_result.index)
            report_mismatch($sformatf("index got %0d exp %0d",
                                      out_result_index, oldest_result.index));
          if (out_status != oldest_result.status)
            report_mismatch($sformatf("status got %0d exp %0d",
                                      out_status, oldest_result.status));
          if (out_last != oldest_result.last)
            report_mismatch($sformatf("last got %0d exp %0d",
                                      out_last, oldest_result.last));
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct(idle_phase));
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("periodic_task_timer_bank_core regression: fail");
      $finish;
    end
  end

  initial begin
    int          burst;
    int          len;
    logic [1:0]  lst;
    logic [3:0]  idx;
    logic [1:0]  full_list;

    foreach (entries_in_list[i]) entries_in_list[i] = 0;
    foreach (gen_count[i]) gen_count[i] = 0;

    // directed: empty and phantom lists, bad indexes, ignored code, period extremes
    queue_request(ptt_pkg::REQ_TICK, 2'd0,    4'd0,  32'd0);
    queue_request(ptt_pkg::REQ_TICK, NO_LIST, 4'd0,  32'd0);
    queue_request(ptt_pkg::REQ_ADD,  NO_LIST, 4'd0,  32'd5);
    queue_request(ptt_pkg::REQ_SET,  NO_LIST, 4'd0,  32'd5);
    queue_request(ptt_pkg::REQ_SET,  2'd0,    4'd0,  32'd3);
    queue_request(REQ_UNUSED,        2'd0,    4'd0,  32'd1);
    queue_request(ptt_pkg::REQ_ADD,  2'd0,    4'd0,  32'd1);
    queue_request(ptt_pkg::REQ_ADD,  2'd0,    4'd0,  32'd0);
    queue_request(ptt_pkg::REQ_ADD,  2'd0,    4'd0,  32'hFFFF_FFFF);
    queue_request(ptt_pkg::REQ_ADD,  2'd0,    4'd0,  32'd2);
    queue_request(ptt_pkg::REQ_TICK, 2'd0,    4'd0,  32'd0);
    queue_request(ptt_pkg::REQ_TICK, 2'd0,    4'd0,  32'd0);
    queue_request(ptt_pkg::REQ_SET,  2'd0,    4'd1,  32'd1);
    queue_request(ptt_pkg::REQ_SET,  2'd0,    4'd15, 32'd7);
    queue_request(ptt_pkg::REQ_TICK, 2'd0,    4'd0,  32'd0);

    // random part opens by saturating an empty list: full reply, then sixteen fires
    full_list = 2'($urandom_range(1, 2));
    while (gen_count[full_list] < TASKS)
      queue_request(ptt_pkg::REQ_ADD, full_list, 4'($urandom), 32'd1);
    queue_request(ptt_pkg::REQ_ADD,  full_list, 4'($urandom), $urandom);
    queue_request(ptt_pkg::REQ_TICK, full_list, 4'($urandom), $urandom);

    // bursts of well-formed traffic with random content, plus some noise
    while (gen_useful < 165) begin
      burst = $urandom_range(0, 99);
      lst   = 2'($urandom_range(0, 2));
      if (burst < 30) begin
        len = $urandom_range(1, 6);
        repeat (len) queue_request(ptt_pkg::REQ_ADD, lst, 4'($urandom), pick_period());
      end else if (burst < 65) begin
        len = $urandom_range(1, 5);
        repeat (len) queue_request(ptt_pkg::REQ_TICK, lst, 4'($urandom), $urandom);
      end else if (burst < 85) begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          if (gen_count[lst] > 0 && $urandom_range(0, 99) < 80)
            idx = 4'($urandom_range(0, gen_count[lst] - 1));
          else
            idx = 4'($urandom);
          queue_request(ptt_pkg::REQ_SET, lst, idx, pick_period());
        end
      end else begin
        queue_request(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                      4'($urandom), $urandom);
      end
    end
    request_total = request_q.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count < request_total) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("periodic_task_timer_bank_core regression: pass");
    end else begin
      $display("periodic_task_timer_bank_core regression: fail");
    end
    $finish;
  end

endmodule
